// File: rtl/core/rtte_pkg.sv
// Shared types and constants for the round-trip time estimator.
package rtte_pkg;

	localparam int TIME_BITS_DEF = 24;
	localparam int FIELD_BITS = 24;
	localparam int NOW_BITS = 48;
	localparam int COUNT_BITS = 32;
	localparam int CFG_INDEX_BITS = 2;

	localparam longint unsigned LOW_BOUND_RESET = 64'd1000;
	localparam longint unsigned HIGH_BOUND_RESET = 64'd10000000;
	localparam longint unsigned FLOOR_RESET = 64'd10000;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_LOW_BOUND = 2'd0,
		REG_HIGH_BOUND = 2'd1,
		REG_FLOOR = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic accepted;
		logic [FIELD_BITS-1:0] srtt;
		logic [FIELD_BITS-1:0] rtt_variation;
		logic [FIELD_BITS-1:0] min_rtt;
		logic [FIELD_BITS-1:0] last_sample;
		logic [COUNT_BITS-1:0] round_count;
		logic have_estimate;
	} result_t;

endpackage

// File: rtl/core/rtt_estimator_unit.sv
// Top level of the round-trip time estimator.
//
// Each sample beat carries an RTT sample, the peer's ack delay and the current
// time, all in microseconds. Every sample beat yields exactly one result beat
// with an accepted flag and the estimator state after that sample: smoothed
// RTT, RTT variation, minimum RTT, last clamped sample, round count and
// whether an estimate exists yet.
// A sample beat lands in an input register; the update then runs on it and
// loads the result register, from which the result beat is offered.
// One sample per cycle is sustained while result_stall is low: the whole
// update is one pass of add, shift and compare logic between those two registers.
// When result_stall is high the result register holds its beat; a sample
// already in the input register waits there and sample_stall rises, so
// nothing is lost. Configuration writes are always ready and apply to the
// next sample that is processed. Reset clears both registers' valid flags and
// the estimator state and loads the default bounds and floor.
module rtt_estimator_unit #(
	parameter int TIME_BITS = rtte_pkg::TIME_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_stall,
	input  logic [rtte_pkg::FIELD_BITS-1:0] rtt_sample_us,
	input  logic [rtte_pkg::FIELD_BITS-1:0] ack_delay_us,
	input  logic [rtte_pkg::NOW_BITS-1:0] now_us,
	output logic result_valid,
	input  logic result_stall,
	output logic accepted,
	output logic [rtte_pkg::FIELD_BITS-1:0] smoothed_rtt_us,
	output logic [rtte_pkg::FIELD_BITS-1:0] rtt_variation_us,
	output logic [rtte_pkg::FIELD_BITS-1:0] min_rtt_us,
	output logic [rtte_pkg::FIELD_BITS-1:0] last_rtt_us,
	output logic [rtte_pkg::COUNT_BITS-1:0] round_count,
	output logic have_estimate,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [rtte_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [rtte_pkg::FIELD_BITS-1:0] cfg_data
);

	logic valid_s1;
	logic [rtte_pkg::FIELD_BITS-1:0] sample_s1;
	logic [rtte_pkg::FIELD_BITS-1:0] delay_s1;
	logic [rtte_pkg::NOW_BITS-1:0] now_s1;
	logic out_valid_q;
	rtte_pkg::result_t out_q;
	rtte_pkg::result_t result;
	logic out_free;
	logic advance;
	logic take;
	logic [TIME_BITS-1:0] low_bound;
	logic [TIME_BITS-1:0] high_bound;
	logic [TIME_BITS-1:0] sample_floor;

	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || !result_stall;
	assign advance = valid_s1 && out_free;
	assign sample_stall = valid_s1 && !out_free;
	assign take = sample_valid && !sample_stall;

	rtte_cfg #(
		.TIME_BITS(TIME_BITS)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cfg_valid && cfg_ready),
		.wr_index(cfg_index),
		.wr_data(cfg_data),
		.low_bound(low_bound),
		.high_bound(high_bound),
		.sample_floor(sample_floor)
	);

	rtte_core #(
		.TIME_BITS(TIME_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(advance),
		.rtt_sample_us(sample_s1),
		.ack_delay_us(delay_s1),
		.now_us(now_s1),
		.low_bound(low_bound),
		.high_bound(high_bound),
		.sample_floor(sample_floor),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1 <= rtt_sample_us;
			delay_s1 <= ack_delay_us;
			now_s1 <= now_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign result_valid = out_valid_q;
	assign accepted = out_q.accepted;
	assign smoothed_rtt_us = out_q.srtt;
	assign rtt_variation_us = out_q.rtt_variation;
	assign min_rtt_us = out_q.min_rtt;
	assign last_rtt_us = out_q.last_sample;
	assign round_count = out_q.round_count;
	assign have_estimate = out_q.have_estimate;

endmodule

// File: rtl/core/rtte_cfg.sv
// Configuration registers: sample bounds and sample floor.
module rtte_cfg #(
	parameter int TIME_BITS = rtte_pkg::TIME_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [rtte_pkg::CFG_INDEX_BITS-1:0] wr_index,
	input  logic [rtte_pkg::FIELD_BITS-1:0] wr_data,
	output logic [TIME_BITS-1:0] low_bound,
	output logic [TIME_BITS-1:0] high_bound,
	output logic [TIME_BITS-1:0] sample_floor
);

	localparam longint unsigned TIME_MAX = (64'd1 << TIME_BITS) - 64'd1;
	// A reset bound beyond the time width accepts every sample, as the full maximum does.
	localparam longint unsigned HIGH_RESET =
		(rtte_pkg::HIGH_BOUND_RESET > TIME_MAX) ? TIME_MAX : rtte_pkg::HIGH_BOUND_RESET;

	logic [31:0] data_ext;
	logic [TIME_BITS-1:0] data_tb;
	logic [TIME_BITS-1:0] low_q;
	logic [TIME_BITS-1:0] high_q;
	logic [TIME_BITS-1:0] floor_q;

	assign data_ext = 32'(wr_data);
	assign data_tb = data_ext[TIME_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= TIME_BITS'(rtte_pkg::LOW_BOUND_RESET);
			high_q <= TIME_BITS'(HIGH_RESET);
			floor_q <= TIME_BITS'(rtte_pkg::FLOOR_RESET);
		end else if (wr_en) begin
			case (rtte_pkg::cfg_reg_t'(wr_index))
				rtte_pkg::REG_LOW_BOUND: low_q <= data_tb;
				rtte_pkg::REG_HIGH_BOUND: high_q <= data_tb;
				rtte_pkg::REG_FLOOR: floor_q <= data_tb;
				default: ;
			endcase
		end
	end

	assign low_bound = low_q;
	assign high_bound = high_q;
	assign sample_floor = floor_q;

endmodule

// File: rtl/core/rtte_core.sv
// Estimator state and its combinational update for one sample.
module rtte_core #(
	parameter int TIME_BITS = rtte_pkg::TIME_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  logic [rtte_pkg::FIELD_BITS-1:0] rtt_sample_us,
	input  logic [rtte_pkg::FIELD_BITS-1:0] ack_delay_us,
	input  logic [rtte_pkg::NOW_BITS-1:0] now_us,
	input  logic [TIME_BITS-1:0] low_bound,
	input  logic [TIME_BITS-1:0] high_bound,
	input  logic [TIME_BITS-1:0] sample_floor,
	output rtte_pkg::result_t result
);

	localparam int SW = TIME_BITS + 2;
	localparam int NW = rtte_pkg::NOW_BITS;

	logic have_q;
	logic [TIME_BITS-1:0] smoothed_q;
	logic [TIME_BITS-1:0] variation_q;
	logic [TIME_BITS-1:0] min_q;
	logic [TIME_BITS-1:0] last_q;
	logic [NW-1:0] round_time_q;
	logic [rtte_pkg::COUNT_BITS-1:0] round_count_q;

	logic [31:0] sample_ext;
	logic [31:0] delay_ext;
	logic [TIME_BITS-1:0] sample;
	logic [TIME_BITS-1:0] delay;
	logic ok;
	logic [TIME_BITS-1:0] clamped;
	logic [TIME_BITS-1:0] min_next;
	logic signed [SW-1:0] net;
	logic [TIME_BITS-1:0] adj;
	logic signed [SW-1:0] sm_diff;
	logic signed [SW-1:0] sm_sum;
	logic [TIME_BITS-1:0] sm_upd;
	logic signed [SW-1:0] gap;
	logic [TIME_BITS-1:0] gap_abs;
	logic signed [SW-1:0] var_diff;
	logic signed [SW-1:0] var_sum;
	logic [TIME_BITS-1:0] var_upd;
	logic [TIME_BITS-1:0] smoothed_next;
	logic [TIME_BITS-1:0] variation_next;
	logic [NW:0] round_end;
	logic new_round;
	logic [31:0] sm_out;
	logic [31:0] var_out;
	logic [31:0] min_out;
	logic [31:0] last_out;

	assign sample_ext = 32'(rtt_sample_us);
	assign delay_ext = 32'(ack_delay_us);
	assign sample = sample_ext[TIME_BITS-1:0];
	assign delay = delay_ext[TIME_BITS-1:0];

	always_comb begin
		ok = (sample >= low_bound) && (sample <= high_bound) && (delay <= high_bound);
		clamped = (sample < sample_floor) ? sample_floor : sample;

		// Later samples track the minimum; the ack delay is taken off only
		// when what remains is still above the updated minimum.
		min_next = (!have_q || clamped < min_q) ? clamped : min_q;
		net = $signed(SW'(clamped)) - $signed(SW'(delay));
		adj = (net > $signed(SW'(min_next))) ? net[TIME_BITS-1:0] : clamped;

		sm_diff = $signed(SW'(adj)) - $signed(SW'(smoothed_q));
		sm_sum = $signed(SW'(smoothed_q)) + (sm_diff >>> 3);
		sm_upd = sm_sum[TIME_BITS-1:0];

		gap = $signed(SW'(sm_upd)) - $signed(SW'(adj));
		gap_abs = (gap < 0) ? TIME_BITS'(-gap) : gap[TIME_BITS-1:0];
		var_diff = $signed(SW'(gap_abs)) - $signed(SW'(variation_q));
		var_sum = $signed(SW'(variation_q)) + (var_diff >>> 2);
		var_upd = var_sum[TIME_BITS-1:0];

		if (!ok) begin
			smoothed_next = smoothed_q;
			variation_next = variation_q;
		end else if (!have_q) begin
			smoothed_next = clamped;
			variation_next = clamped >> 1;
		end else begin
			smoothed_next = sm_upd;
			variation_next = var_upd;
		end

		round_end = (NW+1)'(round_time_q) + (NW+1)'(smoothed_next);
		new_round = ok && ((NW+1)'(now_us) > round_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			smoothed_q <= '0;
			variation_q <= '0;
			min_q <= '0;
			last_q <= '0;
			round_time_q <= '0;
			round_count_q <= '0;
		end else if (fire && ok) begin
			have_q <= 1'b1;
			smoothed_q <= smoothed_next;
			variation_q <= variation_next;
			min_q <= min_next;
			last_q <= clamped;
			if (new_round) begin
				round_time_q <= now_us;
				round_count_q <= round_count_q + 1'b1;
			end
		end
	end

	// The result shows the state as it stands after this sample.
	assign sm_out = 32'(smoothed_next);
	assign var_out = 32'(variation_next);
	assign min_out = 32'(ok ? min_next : min_q);
	assign last_out = 32'(ok ? clamped : last_q);

	always_comb begin
		result.accepted = ok;
		result.srtt = sm_out[rtte_pkg::FIELD_BITS-1:0];
		result.rtt_variation = var_out[rtte_pkg::FIELD_BITS-1:0];
		result.min_rtt = min_out[rtte_pkg::FIELD_BITS-1:0];
		result.last_sample = last_out[rtte_pkg::FIELD_BITS-1:0];
		result.round_count = new_round ? round_count_q + 1'b1 : round_count_q;
		result.have_estimate = have_q || ok;
	end

endmodule
